FILE: hdl/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

   // field and state widths
   localparam int LEVEL_W   = 34;
   localparam int COUNT_W   = 22;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_W     = LEVEL_W + 1;

   // Q1.31 full scale and the longest ramp count
   localparam logic [LEVEL_W-1:0] ONE_Q31   = LEVEL_W'(64'h8000_0000);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // ms to samples: round(ms * rate / 1000)
   localparam int ROUND_DIVISOR = 1000;
   localparam int ROUND_BIAS    = 500;

   // x / 1000 == (x * RECIP_K) >> RECIP_SHIFT, exact for any x below 2^32
   localparam int               RECIP_W     = 29;
   localparam int               RECIP_SHIFT = 38;
   localparam logic [RECIP_W-1:0] RECIP_K   = 29'd274877907;

   // request commands
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AMPLITUDE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_MS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_MS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_MS    = 3'd4;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_MUL,
      OP_OUT,
      OP_SET_LEVEL,
      OP_RAMP_BEGIN,
      OP_LOAD_N,
      OP_DIV_STEP,
      OP_LOAD_STEP,
      OP_DIV_CNT,
      OP_LOAD_CNT
   } op_type;

   typedef enum logic [1:0] {
      TGT_ZERO,
      TGT_ONE,
      TGT_SUSTAIN
   } target_type;

   typedef enum logic [1:0] {
      TIME_ATTACK,
      TIME_DECAY,
      TIME_RELEASE
   } time_type;

   typedef struct packed {
      op_type     op;
      target_type tgt;
      time_type   tsel;
   } ctrl_type;

   typedef struct packed {
      logic steps_one;
      logic out_free;
      logic div_done;
      logic quot_zero;
      logic attack_zero;
      logic decay_zero;
      logic release_zero;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/adsr_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned.
module adsr_divider import adsr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   // shift in the next dividend bit, try the subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ~diff[DIV_W]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/adsr_datapath.sv
`default_nettype none

module adsr_datapath import adsr_pkg::*; #(
   parameter int SAMPLE_RATE_HZ = 48000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   output status_type           status,
   input  logic                 req_mod_present,
   input  logic signed [15:0]   req_mod_sample,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_sample_out
);

   // ramp length widths follow from the sample rate
   localparam longint MS_MAX = (longint'(1) << CFG_W) - 1;
   localparam longint X_MAX  = MS_MAX * SAMPLE_RATE_HZ + ROUND_BIAS;
   localparam int     X_W    = $clog2(X_MAX + 1);
   localparam int     N_W    = $clog2(X_MAX / ROUND_DIVISOR + 1);
   localparam int     NP_W   = X_W + RECIP_W;

   // output arithmetic widths
   localparam int Q_FRAC   = 31;
   localparam int OUT_FRAC = 15;
   localparam int MOD_W    = 17;
   localparam int P1_W     = LEVEL_W + CFG_W + 1;
   localparam int T_W      = P1_W - Q_FRAC;
   localparam int P2_W     = T_W + MOD_W;
   localparam int R_W      = P2_W - OUT_FRAC;

   localparam logic [X_W-1:0]          RATE_K    = X_W'(SAMPLE_RATE_HZ);
   localparam logic signed [MOD_W-1:0] MOD_UNITY = 17'sh0_8000;
   localparam logic signed [P1_W-1:0]  P1_HALF   = P1_W'(1) <<< (Q_FRAC - 1);
   localparam logic signed [P2_W-1:0]  P2_HALF   = P2_W'(1) <<< (OUT_FRAC - 1);
   localparam logic signed [R_W-1:0]   SAT_HI    = R_W'(32767);
   localparam logic signed [R_W-1:0]   SAT_LO    = R_W'(-32768);

   // configuration registers
   logic [CFG_W-1:0] amp_ff, amp_in;
   logic [CFG_W-1:0] attack_ff, attack_in;
   logic [CFG_W-1:0] decay_ff, decay_in;
   logic [CFG_W-1:0] sustain_ff, sustain_in;
   logic [CFG_W-1:0] release_ff, release_in;

   // envelope state
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [LEVEL_W-1:0] step_ff, step_in;
   logic [COUNT_W-1:0]        steps_ff, steps_in;

   // output pipeline
   logic signed [MOD_W-1:0] mod_ff, mod_in;
   logic signed [P1_W-1:0]  p1_ff, p1_in;
   logic signed [P2_W-1:0]  p2_ff, p2_in;
   logic signed [15:0]      sample_ff, sample_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // ramp setup
   logic [X_W-1:0]     x_ff, x_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [DIV_W-1:0]   ad_ff, ad_in;
   logic               dneg_ff, dneg_in;
   logic [LEVEL_W-1:0] as_ff, as_in;
   logic [NP_W-1:0]    n_prod;

   logic signed [LEVEL_W-1:0] tgt_val;
   logic [CFG_W-1:0]          tm_val;
   logic signed [DIV_W-1:0]   delta;
   logic signed [CFG_W:0]     amp_s;
   logic signed [P1_W-1:0]    p1_rnd;
   logic signed [T_W-1:0]     t_val;
   logic signed [P2_W-1:0]    p2_rnd;
   logic signed [R_W-1:0]     r_val;
   logic signed [15:0]        r_sat;
   logic [LEVEL_W-1:0]        q_lv;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;

   adsr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ramp target and time
   always_comb begin
      case (ctrl.tgt)
         TGT_ONE:     tgt_val = ONE_Q31;
         TGT_SUSTAIN: tgt_val = LEVEL_W'({sustain_ff, {CFG_W{1'b0}}});
         default:     tgt_val = '0;
      endcase
      case (ctrl.tsel)
         TIME_ATTACK: tm_val = attack_ff;
         TIME_DECAY:  tm_val = decay_ff;
         default:     tm_val = release_ff;
      endcase
   end

   // ramp length: (ms x rate + 500) / 1000 by reciprocal multiply
   always_comb begin
      n_prod = NP_W'(x_ff) * NP_W'(RECIP_K);
   end

   // divider operands
   always_comb begin
      div_start    = 1'b0;
      div_dividend = ad_ff;
      div_divisor  = DIV_W'(n_ff);
      case (ctrl.op)
         OP_DIV_STEP: begin
            div_start = 1'b1;
         end
         OP_DIV_CNT: begin
            // round to nearest: (|delta| + |step|/2) / |step|
            div_start    = 1'b1;
            div_dividend = ad_ff + DIV_W'(as_ff >> 1);
            div_divisor  = DIV_W'(as_ff);
         end
         default: ;
      endcase
   end

   // output arithmetic: level x gain, then x modulation, round, saturate
   always_comb begin
      amp_s  = $signed({1'b0, amp_ff});
      p1_in  = level_ff * amp_s;
      p1_rnd = p1_ff + P1_HALF;
      t_val  = p1_rnd[P1_W-1:Q_FRAC];
      p2_in  = t_val * mod_ff;
      p2_rnd = p2_ff + P2_HALF;
      r_val  = p2_rnd[P2_W-1:OUT_FRAC];
      if (r_val > SAT_HI) begin
         r_sat = 16'sh7FFF;
      end else if (r_val < SAT_LO) begin
         r_sat = 16'sh8000;
      end else begin
         r_sat = r_val[15:0];
      end
      mod_in = req_mod_present ? MOD_W'(req_mod_sample) : MOD_UNITY;
   end

   // next state of registers
   always_comb begin
      amp_in       = amp_ff;
      attack_in    = attack_ff;
      decay_in     = decay_ff;
      sustain_in   = sustain_ff;
      release_in   = release_ff;
      level_in     = level_ff;
      step_in      = step_ff;
      steps_in     = steps_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      x_in         = x_ff;
      n_in         = n_ff;
      ad_in        = ad_ff;
      dneg_in      = dneg_ff;
      as_in        = as_ff;
      delta        = DIV_W'(tgt_val) - DIV_W'(level_ff);
      q_lv         = div_quotient[LEVEL_W-1:0];

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_AMPLITUDE: amp_in     = csr_wdata;
            CSR_ATTACK_MS:     attack_in  = csr_wdata;
            CSR_DECAY_MS:      decay_in   = csr_wdata;
            CSR_SUSTAIN_LEVEL: sustain_in = csr_wdata;
            CSR_RELEASE_MS:    release_in = csr_wdata;
            default: ;
         endcase
      end

      case (ctrl.op)
         OP_TICK: begin
            // product uses the level before this tick's step
            if (steps_ff != '0) begin
               steps_in = steps_ff - COUNT_W'(1);
               level_in = level_ff + step_ff;
            end
         end
         OP_OUT: begin
            sample_in    = r_sat;
            rsp_valid_in = 1'b1;
         end
         OP_SET_LEVEL: begin
            level_in = tgt_val;
            step_in  = '0;
            steps_in = '0;
         end
         OP_RAMP_BEGIN: begin
            x_in    = X_W'(tm_val) * RATE_K + X_W'(ROUND_BIAS);
            dneg_in = delta[DIV_W-1];
            ad_in   = delta[DIV_W-1] ? DIV_W'(-delta) : DIV_W'(delta);
         end
         OP_LOAD_N: begin
            n_in = n_prod[RECIP_SHIFT +: N_W];
         end
         OP_LOAD_STEP: begin
            // step truncates toward zero; a zero step holds the stage
            as_in   = q_lv;
            step_in = dneg_ff ? -$signed(q_lv) : $signed(q_lv);
            if (div_quotient == '0) begin
               steps_in = '0;
            end
         end
         OP_LOAD_CNT: begin
            if (div_quotient > DIV_W'(COUNT_MAX)) begin
               steps_in = COUNT_MAX;
            end else begin
               steps_in = div_quotient[COUNT_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff       <= CFG_W'(32768);
         attack_ff    <= '0;
         decay_ff     <= '0;
         sustain_ff   <= CFG_W'(32768);
         release_ff   <= '0;
         level_ff     <= '0;
         step_ff      <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         amp_ff       <= amp_in;
         attack_ff    <= attack_in;
         decay_ff     <= decay_in;
         sustain_ff   <= sustain_in;
         release_ff   <= release_in;
         level_ff     <= level_in;
         step_ff      <= step_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_TICK) begin
         mod_ff <= mod_in;
         p1_ff  <= p1_in;
      end
      if (ctrl.op == OP_MUL) begin
         p2_ff <= p2_in;
      end
      sample_ff <= sample_in;
      x_ff      <= x_in;
      n_ff      <= n_in;
      ad_ff     <= ad_in;
      dneg_ff   <= dneg_in;
      as_ff     <= as_in;
   end

   // status to the controller
   always_comb begin
      status.steps_one    = (steps_ff == COUNT_W'(1));
      status.out_free     = ~rsp_valid_ff | rsp_ready;
      status.div_done     = div_done;
      status.quot_zero    = (div_quotient == '0);
      status.attack_zero  = (attack_ff == '0);
      status.decay_zero   = (decay_ff == '0);
      status.release_zero = (release_ff == '0);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;

endmodule

`default_nettype wire

FILE: hdl/adsr_controller.sv
`default_nettype none

module adsr_controller import adsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_cmd,
   output logic       req_ready,
   input  status_type status,
   output ctrl_type   ctrl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK_MUL,
      S_TICK_OUT,
      S_ATTACK,
      S_DECAY,
      S_RELEASE,
      S_N_START,
      S_STEP_START,
      S_STEP_WAIT,
      S_CNT_START,
      S_CNT_WAIT
   } state_type;

   typedef enum logic [1:0] {
      STG_IDLE,
      STG_ATTACK,
      STG_DECAY,
      STG_RELEASE
   } stage_type;

   state_type state_ff, state_in;
   stage_type stage_ff, stage_in;
   logic      decay_pend_ff, decay_pend_in;

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      decay_pend_in = decay_pend_ff;
      ctrl.op       = OP_NONE;
      ctrl.tgt      = TGT_ZERO;
      ctrl.tsel     = TIME_ATTACK;
      req_ready     = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_TICK: begin
                     // last attack step hands over to decay after the beat
                     ctrl.op       = OP_TICK;
                     decay_pend_in = (stage_ff == STG_ATTACK) && status.steps_one;
                     state_in      = S_TICK_MUL;
                  end
                  CMD_NOTE_ON:  state_in = S_ATTACK;
                  CMD_NOTE_OFF: state_in = S_RELEASE;
                  default: ;
               endcase
            end
         end
         S_TICK_MUL: begin
            ctrl.op  = OP_MUL;
            state_in = S_TICK_OUT;
         end
         S_TICK_OUT: begin
            if (status.out_free) begin
               ctrl.op  = OP_OUT;
               state_in = decay_pend_ff ? S_DECAY : S_IDLE;
            end
         end
         S_ATTACK: begin
            stage_in  = STG_ATTACK;
            ctrl.tgt  = status.decay_zero ? TGT_SUSTAIN : TGT_ONE;
            ctrl.tsel = TIME_ATTACK;
            if (status.attack_zero) begin
               ctrl.op  = OP_SET_LEVEL;
               state_in = S_DECAY;
            end else begin
               ctrl.op  = OP_RAMP_BEGIN;
               state_in = S_N_START;
            end
         end
         S_DECAY: begin
            stage_in      = STG_DECAY;
            decay_pend_in = 1'b0;
            ctrl.tgt      = TGT_SUSTAIN;
            ctrl.tsel     = TIME_DECAY;
            if (status.decay_zero) begin
               ctrl.op  = OP_SET_LEVEL;
               state_in = S_IDLE;
            end else begin
               ctrl.op  = OP_RAMP_BEGIN;
               state_in = S_N_START;
            end
         end
         S_RELEASE: begin
            stage_in  = STG_RELEASE;
            ctrl.tgt  = TGT_ZERO;
            ctrl.tsel = TIME_RELEASE;
            if (status.release_zero) begin
               ctrl.op  = OP_SET_LEVEL;
               state_in = S_IDLE;
            end else begin
               ctrl.op  = OP_RAMP_BEGIN;
               state_in = S_N_START;
            end
         end
         // ramp length in samples
         S_N_START: begin
            ctrl.op  = OP_LOAD_N;
            state_in = S_STEP_START;
         end
         // step per sample
         S_STEP_START: begin
            ctrl.op  = OP_DIV_STEP;
            state_in = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (status.div_done) begin
               ctrl.op  = OP_LOAD_STEP;
               state_in = status.quot_zero ? S_IDLE : S_CNT_START;
            end
         end
         // sample count of the ramp
         S_CNT_START: begin
            ctrl.op  = OP_DIV_CNT;
            state_in = S_CNT_WAIT;
         end
         S_CNT_WAIT: begin
            if (status.div_done) begin
               ctrl.op  = OP_LOAD_CNT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stage_ff      <= STG_IDLE;
         decay_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         decay_pend_ff <= decay_pend_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/adsr_envelope_generator.sv
`default_nettype none

// Channel  Handshake              Beat contents
// req      req_valid / req_ready  req_cmd, req_mod_present, req_mod_sample
// rsp      rsp_valid / rsp_ready  rsp_sample_out (one beat per sample tick)
// csr      csr_we, never stalls   csr_index, csr_wdata
//
// A sample tick runs the tick, multiply and output states; a note on/off with no ramp
// just sets the level. Starting a ramp (note on, note off, or the tick that ends the
// attack) takes a reciprocal multiply for the length, then bit-serial divisions in the
// shared divider: one for the step and, when the step is not zero, one for the count.
// One item is worked on at a time; req_ready is high only when nothing is in flight.
// The rsp beat sits in an output register until rsp_ready; a tick waits for it only
// when writing its own beat. Reset is synchronous: registers to defaults, level zero.
module adsr_envelope_generator import adsr_pkg::*; #(
   parameter int SAMPLE_RATE_HZ = 48000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic                 req_mod_present,
   input  logic signed [15:0]   req_mod_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_sample_out,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   ctrl_type   ctrl;
   status_type status;

   adsr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   adsr_datapath #(
      .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_mod_present (req_mod_present),
      .req_mod_sample  (req_mod_sample),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_sample_out  (rsp_sample_out)
   );

endmodule

`default_nettype wire

FILE: hdl/adsr_checker.sv
`default_nettype none

module adsr_checker import adsr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_cmd,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] rsp_sample_out
);

   // a waiting rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("rsp beat changed while stalled");

   // reset leaves no beat behind
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // every valid command makes the block busy, so req_ready is low in the next cycle
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_cmd == CMD_TICK || req_cmd == CMD_NOTE_ON || req_cmd == CMD_NOTE_OFF)
      |=> !req_ready)
      else $error("ready stayed high after a command");

   // the unused command is dropped without a beat
   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      req_cmd != CMD_TICK && req_cmd != CMD_NOTE_ON && req_cmd != CMD_NOTE_OFF
      |=> req_ready && !$rose(rsp_valid))
      else $error("unused command was acted on");

   // a new beat only comes while the block is busy, not while idle
   a_beat_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp beat appeared while idle");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

`default_nettype wire

FILE: tb/tb_adsr_envelope_generator.sv
`timescale 1ns / 100ps

module tb_adsr_envelope_generator;
   import adsr_pkg::*;

   localparam int RATE_HZ       = 48000;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_ITEMS   = 78;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam longint HALF_Q31  = 64'sd1073741824;
   localparam longint HALF_Q15  = 64'sd16384;
   localparam longint UNITY_Q15 = 64'sd32768;
   localparam longint SUSTAIN_SCALE = 64'sd65536;

   typedef enum logic [1:0] {
      ENV_IDLE,
      ENV_ATTACK,
      ENV_DECAY,
      ENV_RELEASE
   } env_stage_type;

   // Envelope predictor plus the queue of samples it still owes the rsp side
   class envelope_scoreboard;
      bit [CFG_W-1:0]            gain, attack_ms, decay_ms, sustain, release_ms;
      env_stage_type             stage;
      logic signed [LEVEL_W-1:0] level, step_size;
      logic [COUNT_W-1:0]        steps_left;
      logic signed [15:0]        expected_samples[$];
      int                        errors;

      function new();
         gain       = 16'd32768;
         attack_ms  = '0;
         decay_ms   = '0;
         sustain    = 16'd32768;
         release_ms = '0;
         stage      = ENV_IDLE;
         level      = '0;
         step_size  = '0;
         steps_left = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_MAX_AMPLITUDE: gain = val;
            CSR_ATTACK_MS:     attack_ms = val;
            CSR_DECAY_MS:      decay_ms = val;
            CSR_SUSTAIN_LEVEL: sustain = val;
            CSR_RELEASE_MS:    release_ms = val;
            default: ;
         endcase
      endfunction

      function longint sustain_q31();
         return longint'(sustain) * SUSTAIN_SCALE;
      endfunction

      // step = delta / samples (toward zero), count = round(|delta| / |step|)
      function void launch_ramp(longint target, bit [CFG_W-1:0] ms);
         longint delta, n, stp, mag_delta, mag_step, cnt;
         delta = target - longint'(level);
         n = (longint'(ms) * RATE_HZ + ROUND_BIAS) / ROUND_DIVISOR;
         if (n <= 0) n = 1;
         stp = delta / n;
         step_size = LEVEL_W'(stp);
         if (stp == 0) begin
            steps_left = '0;
            return;
         end
         mag_delta = delta < 0 ? -delta : delta;
         mag_step  = stp < 0 ? -stp : stp;
         cnt = (mag_delta + mag_step / 2) / mag_step;
         steps_left = (cnt > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt);
      endfunction

      function void go_decay();
         stage = ENV_DECAY;
         if (decay_ms != 0) begin
            launch_ramp(sustain_q31(), decay_ms);
            return;
         end
         level      = LEVEL_W'(sustain_q31());
         step_size  = '0;
         steps_left = '0;
      endfunction

      function void start_note();
         longint target;
         target = (decay_ms != 0) ? longint'(ONE_Q31) : sustain_q31();
         stage = ENV_ATTACK;
         if (attack_ms != 0) begin
            launch_ramp(target, attack_ms);
            return;
         end
         level = LEVEL_W'(target);
         go_decay();
      endfunction

      function void end_note();
         stage = ENV_RELEASE;
         if (release_ms != 0) begin
            launch_ramp(0, release_ms);
            return;
         end
         level      = '0;
         step_size  = '0;
         steps_left = '0;
      endfunction

      // output sample for the current level, then one ramp step
      function logic signed [15:0] envelope_tick(logic mod_on, logic signed [15:0] mod_in);
         longint factor, scaled, mixed;
         factor = mod_on ? longint'(mod_in) : UNITY_Q15;
         scaled = (longint'(level) * longint'(gain) + HALF_Q31) >>> 31;
         mixed  = (scaled * factor + HALF_Q15) >>> 15;
         if (mixed > 32767) mixed = 32767;
         else if (mixed < -32768) mixed = -32768;
         if (steps_left != 0) begin
            steps_left = steps_left - 1'b1;
            level = level + step_size;
            if (stage != ENV_RELEASE && steps_left == 0) begin
               if (stage == ENV_IDLE) start_note();
               else if (stage == ENV_ATTACK) go_decay();
            end
         end
         return 16'(mixed);
      endfunction

      function void note_request(logic [1:0] cmd, logic mod_on, logic signed [15:0] mod_in);
         case (cmd)
            CMD_TICK:     expected_samples.push_back(envelope_tick(mod_on, mod_in));
            CMD_NOTE_ON:  start_note();
            CMD_NOTE_OFF: end_note();
            default: ;
         endcase
      endfunction

      function void check_sample(logic signed [15:0] actual);
         logic signed [15:0] want;
         if (expected_samples.size() == 0) begin
            $error("sample_out: no beat expected, actual %0d", actual);
            errors++;
            return;
         end
         want = expected_samples.pop_front();
         if (actual !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_cmd = CMD_TICK;
   logic                 req_mod_present = 1'b0;
   logic signed [15:0]   req_mod_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [15:0]   rsp_sample_out;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   envelope_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;

   adsr_envelope_generator #(
      .SAMPLE_RATE_HZ(RATE_HZ)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_mod_present(req_mod_present),
      .req_mod_sample(req_mod_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // rsp side: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // every accepted rsp beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_sample_out);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[adsr_envelope_generator] ERROR");
      $finish;
   end

   // one req beat, with random idle cycles ahead of it
   task automatic send_item(logic [1:0] cmd, logic mod_on, logic signed [15:0] mod_in);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_mod_present <= mod_on;
      req_mod_sample  <= mod_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, mod_on, mod_in);
   endtask

   // stop offering, wait for all predicted samples, then let the block settle
   task automatic quiesce(int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_samples.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // all five registers, plus a write to an unmapped index that must be dropped
   task automatic program_regs(logic [CFG_W-1:0] amp, logic [CFG_W-1:0] atk,
                               logic [CFG_W-1:0] dec, logic [CFG_W-1:0] sus,
                               logic [CFG_W-1:0] rel);
      write_reg(CSR_MAX_AMPLITUDE, amp);
      write_reg(CSR_ATTACK_MS, atk);
      write_reg(CSR_DECAY_MS, dec);
      write_reg(CSR_SUSTAIN_LEVEL, sus);
      write_reg(CSR_RELEASE_MS, rel);
      write_reg(CSR_IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly ticks so ramps run through; notes on/off and unused commands mixed in
   task automatic run_random(int n_items, int idle_pct, int stall, bit hold, bit pause_mid);
      int sent;
      int pick;
      logic [1:0] cmd;
      logic signed [15:0] mod_in;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      if (hold) hold_request = 1'b1;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 84) cmd = CMD_TICK;
         else if (pick < 91) cmd = CMD_NOTE_ON;
         else if (pick < 98) cmd = CMD_NOTE_OFF;
         else cmd = CMD_UNUSED;
         if ($urandom_range(9) == 0) mod_in = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         else mod_in = 16'($urandom);
         send_item(cmd, 1'($urandom), mod_in);
         if (cmd != CMD_UNUSED) sent++;
         if (pause_mid && sent == n_items / 2) begin
            quiesce(0);
            pause_mid = 1'b0;
         end
      end
      quiesce(SETTLE_CYCLES);
   endtask

   initial begin
      int idle_pct;
      int stall;
      logic [CFG_W-1:0] atk, dec, rel;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, note off while idle, unused command,
      // jump to full level, both output extremes (top one clipped), ignored mod sample
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      send_item(CMD_NOTE_OFF, 1'b0, 16'sh0000);
      send_item(CMD_UNUSED, 1'b1, 16'shFFFF);
      send_item(CMD_TICK, 1'b1, 16'sh0000);
      send_item(CMD_NOTE_ON, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b1, 16'sh8000);
      send_item(CMD_TICK, 1'b1, 16'sh7FFF);
      send_item(CMD_TICK, 1'b0, 16'shFFFF);
      quiesce(SETTLE_CYCLES);

      // low sustain, longest release: step of one, count saturates
      program_regs(16'd32768, 16'd0, 16'd0, 16'd80, 16'd65535);
      send_item(CMD_NOTE_ON, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      send_item(CMD_NOTE_OFF, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b1, 16'sh4000);
      quiesce(SETTLE_CYCLES);

      // zero gain, longest attack and decay, release that drops at once
      program_regs(16'd0, 16'd65535, 16'd65535, 16'd32768, 16'd0);
      send_item(CMD_NOTE_ON, 1'b1, 16'sh1234);
      send_item(CMD_TICK, 1'b1, 16'sh7FFF);
      send_item(CMD_NOTE_OFF, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      quiesce(SETTLE_CYCLES);

      // decay toward a sustain equal to the level: zero step, holds
      program_regs(16'd32768, 16'd0, 16'd1, 16'd32768, 16'd1);
      send_item(CMD_NOTE_ON, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      quiesce(SETTLE_CYCLES);

      // attack from full level to full level: zero step in attack, then release
      program_regs(16'd32768, 16'd1, 16'd1, 16'd32768, 16'd1);
      send_item(CMD_NOTE_ON, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b1, 16'sh3039);
      send_item(CMD_NOTE_OFF, 1'b0, 16'sh0000);
      send_item(CMD_TICK, 1'b0, 16'sh0000);
      quiesce(SETTLE_CYCLES);

      // random phases, cycling through the idle/stall mixes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall = 0;  end
            1: begin idle_pct = 79; stall = 0;  end
            2: begin idle_pct = 0;  stall = 79; end
            default: begin idle_pct = 36; stall = 36; end
         endcase
         case (phase)
            0: program_regs(16'd32768, 16'd1, 16'd1, 16'd16384, 16'd1);
            1: program_regs(16'd24576, 16'd2, 16'd1, 16'd8192, 16'd3);
            2: program_regs(16'd32768, 16'd1, 16'd0, 16'd0, 16'd1);
            default: begin
               atk = CFG_W'($urandom_range(3));
               dec = CFG_W'($urandom_range(3));
               rel = CFG_W'($urandom_range(3));
               if ($urandom_range(3) == 0) atk = CFG_W'($urandom);
               if ($urandom_range(3) == 0) rel = CFG_W'($urandom);
               program_regs(CFG_W'($urandom_range(32768)), atk, dec,
                            CFG_W'($urandom_range(32768)), rel);
            end
         endcase
         run_random(PHASE_ITEMS, idle_pct, stall, phase == 4, phase == 1);
      end

      if (sb.errors == 0) begin
         $display("[adsr_envelope_generator] OK");
      end else begin
         $display("[adsr_envelope_generator] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/adsr_pkg.sv
hdl/adsr_divider.sv
hdl/adsr_datapath.sv
hdl/adsr_controller.sv
hdl/adsr_envelope_generator.sv
hdl/adsr_checker.sv
tb/tb_adsr_envelope_generator.sv
